>>> src/mtag_pkg.sv
package mtag_pkg;

   localparam int MAX_TILES_PER_DIM = 4;

   localparam int DIM_W      = 16;
   localparam int ADDR_W     = 32;
   localparam int ID_W       = 32;
   localparam int ARR_W      = 9;
   localparam int ACC_W      = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   localparam int CNT_W = $clog2(MAX_TILES_PER_DIM + 1);
   localparam int IDX_W = (MAX_TILES_PER_DIM > 1) ? $clog2(MAX_TILES_PER_DIM) : 1;

   localparam logic [ARR_W-1:0] ARRAY_WIDTH_RESET  = ARR_W'(128);
   localparam logic [ARR_W-1:0] ARRAY_HEIGHT_RESET = ARR_W'(128);
   localparam logic [ACC_W-1:0] ACCUM_DEPTH_RESET  = ACC_W'(256);
   localparam logic [ID_W-1:0]  TILE_ID_RESET      = ID_W'(1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ARRAY_WIDTH  = 2'd0,
      CSR_ARRAY_HEIGHT = 2'd1,
      CSR_ACCUM_DEPTH  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]  rows_a;
      logic [DIM_W-1:0]  inner_b;
      logic [DIM_W-1:0]  cols_c;
      logic              layout_nchw;
      logic [DIM_W-1:0]  channels;
      logic [ADDR_W-1:0] weight_base;
      logic [ADDR_W-1:0] act_base;
   } req_payload_type;

   typedef struct packed {
      logic [ID_W-1:0]   tile_id;
      logic [ADDR_W-1:0] weight_addr;
      logic [ARR_W-1:0]  weight_cols;
      logic [ARR_W-1:0]  weight_rows;
      logic [ADDR_W-1:0] act_addr;
      logic [ACC_W-1:0]  act_cols;
      logic [ARR_W-1:0]  act_rows;
      logic [DIM_W-1:0]  full_cols;
      logic [DIM_W-1:0]  full_rows;
      logic              last;
      logic              error;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic count;
      logic scale;
      logic advance;
      logic show_err;
   } dp_cmd_type;

   typedef struct packed {
      logic err;
      logic zero;
      logic last;
   } dp_status_type;

endpackage

>>> src/mtag_if.sv
interface mtag_req_if import mtag_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mtag_rsp_if import mtag_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> src/matmul_tile_address_generator_core.sv
// Tiled matrix multiply address generator.
// req_if takes one command item: matrix dimensions, layout, channel count
// and the two base addresses. rsp_if returns one item per weight and
// activation tile pair, in row tile, column tile, inner tile order; the
// final pair carries last. A command with a tile count above the limit on
// any dimension returns a single item with error and last set.
// csr_* writes array width, array height and accumulator depth; a zero
// value acts as one. Write only while no command is in flight.
// After a command is accepted, the count state registers the tile count
// compares and the scale state the offset multiplier results; the first
// item is then valid. Tiles follow one per cycle while rsp_if.ready is
// high. Unless another dimension is over the limit, a command with a zero
// dimension returns nothing. One command is in flight at a time;
// req_if.ready is low until its last item is taken. When rsp_if.ready
// is low the current item holds. Reset restores the register defaults
// and sets the tile id counter to 1; the counter carries over between
// commands.
module matmul_tile_address_generator_core import mtag_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mtag_req_if.sink              req_if,
   mtag_rsp_if.source            rsp_if,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   mtag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   mtag_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_payload (req_if.payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_if.payload)
   );

endmodule

>>> src/mtag_ctrl.sv
module mtag_ctrl import mtag_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_COUNT = 5'b00010,
      S_SCALE = 5'b00100,
      S_EMIT  = 5'b01000,
      S_ERR   = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            cmd.count = 1'b1;
            state_in  = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            if (status.err) begin
               state_in = S_ERR;
            end else if (status.zero) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               if (status.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ERR: begin
            rsp_valid    = 1'b1;
            cmd.show_err = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/mtag_datapath.sv
module mtag_datapath import mtag_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  req_payload_type       req_payload,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output rsp_payload_type       rsp_payload
);

   localparam int CMP_W  = (DIM_W > ACC_W + CNT_W) ? DIM_W : ACC_W + CNT_W;
   localparam int HB_W   = ARR_W + DIM_W;
   localparam int FD_W   = ACC_W + DIM_W;
   localparam int PROD_W = HB_W + DIM_W;

   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic             over;
   } count_type;

   function automatic count_type tile_count(input logic [DIM_W-1:0] total,
                                            input logic [ACC_W-1:0] size);
      count_type res;
      res.cnt  = '0;
      res.over = 1'b0;
      for (int m = 0; m < MAX_TILES_PER_DIM; m++) begin
         if (CMP_W'(total) > CMP_W'(m) * CMP_W'(size)) begin
            res.cnt = res.cnt + CNT_W'(1);
         end
      end
      res.over = CMP_W'(total) > CMP_W'(MAX_TILES_PER_DIM) * CMP_W'(size);
      return res;
   endfunction

   logic [ARR_W-1:0] cfg_w_ff, cfg_w_in;
   logic [ARR_W-1:0] cfg_h_ff, cfg_h_in;
   logic [ACC_W-1:0] cfg_d_ff, cfg_d_in;
   logic [ID_W-1:0]  id_ff, id_in;

   logic [DIM_W-1:0]  ra_ff, ra_in;
   logic [DIM_W-1:0]  ib_ff, ib_in;
   logic [DIM_W-1:0]  cc_ff, cc_in;
   logic [DIM_W-1:0]  f_ff, f_in;
   logic [ADDR_W-1:0] wbase_ff, wbase_in;
   logic [ADDR_W-1:0] abase_ff, abase_in;
   logic [ARR_W-1:0]  w_ff, w_in;
   logic [ARR_W-1:0]  h_ff, h_in;
   logic [ACC_W-1:0]  d_ff, d_in;

   logic [CNT_W-1:0] na_ff, na_in;
   logic [CNT_W-1:0] nb_ff, nb_in;
   logic [CNT_W-1:0] nc_ff, nc_in;
   logic             err_ff, err_in;
   logic             zero_ff, zero_in;
   logic [HB_W-1:0]  hb_ff, hb_in;
   logic [HB_W-1:0]  wc_ff, wc_in;
   logic [HB_W-1:0]  fw_ff, fw_in;
   logic [FD_W-1:0]  fd_ff, fd_in;

   logic [ADDR_W-1:0] wrow_step_ff, wrow_step_in;
   logic [ADDR_W-1:0] aj_step_ff, aj_step_in;
   logic [ARR_W-1:0]  rem_a_ff, rem_a_in;
   logic [ARR_W-1:0]  rem_b_ff, rem_b_in;
   logic [ACC_W-1:0]  rem_c_ff, rem_c_in;

   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [ADDR_W-1:0] wrow_ff, wrow_in;
   logic [ADDR_W-1:0] wcur_ff, wcur_in;
   logic [ADDR_W-1:0] akb_ff, akb_in;
   logic [ADDR_W-1:0] acur_ff, acur_in;

   count_type         cnt_a, cnt_b, cnt_c;
   logic [PROD_W-1:0] wrow_full, aj_full;
   logic [DIM_W-1:0]  diff_a, diff_b, diff_c;
   logic              i_last, j_last, k_last;
   logic [ADDR_W-1:0] wrow_next, akb_next;

   always_comb begin
      cfg_w_in = cfg_w_ff;
      cfg_h_in = cfg_h_ff;
      cfg_d_in = cfg_d_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ARRAY_WIDTH:  cfg_w_in = csr_wr_data[ARR_W-1:0];
            CSR_ARRAY_HEIGHT: cfg_h_in = csr_wr_data[ARR_W-1:0];
            CSR_ACCUM_DEPTH:  cfg_d_in = csr_wr_data[ACC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cnt_a = tile_count(ra_ff, ACC_W'(h_ff));
   assign cnt_b = tile_count(ib_ff, ACC_W'(w_ff));
   assign cnt_c = tile_count(cc_ff, d_ff);

   assign wrow_full = PROD_W'(f_ff) * PROD_W'(hb_ff);
   assign aj_full   = PROD_W'(f_ff) * PROD_W'(wc_ff);

   assign diff_a = ra_ff - DIM_W'(na_ff - CNT_W'(1)) * DIM_W'(h_ff);
   assign diff_b = ib_ff - DIM_W'(nb_ff - CNT_W'(1)) * DIM_W'(w_ff);
   assign diff_c = cc_ff - DIM_W'(nc_ff - CNT_W'(1)) * DIM_W'(d_ff);

   assign i_last = CNT_W'(i_ff) == na_ff - CNT_W'(1);
   assign j_last = CNT_W'(j_ff) == nb_ff - CNT_W'(1);
   assign k_last = CNT_W'(k_ff) == nc_ff - CNT_W'(1);

   assign wrow_next = wrow_ff + wrow_step_ff;
   assign akb_next  = akb_ff + ADDR_W'(fd_ff);

   always_comb begin
      ra_in    = ra_ff;
      ib_in    = ib_ff;
      cc_in    = cc_ff;
      f_in     = f_ff;
      wbase_in = wbase_ff;
      abase_in = abase_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      d_in     = d_ff;
      if (cmd.load) begin
         ra_in    = req_payload.rows_a;
         ib_in    = req_payload.inner_b;
         cc_in    = req_payload.cols_c;
         f_in     = req_payload.layout_nchw ? DIM_W'(1) : req_payload.channels;
         wbase_in = req_payload.weight_base;
         abase_in = req_payload.act_base;
         w_in     = (cfg_w_ff == '0) ? ARR_W'(1) : cfg_w_ff;
         h_in     = (cfg_h_ff == '0) ? ARR_W'(1) : cfg_h_ff;
         d_in     = (cfg_d_ff == '0) ? ACC_W'(1) : cfg_d_ff;
      end
   end

   always_comb begin
      na_in   = na_ff;
      nb_in   = nb_ff;
      nc_in   = nc_ff;
      err_in  = err_ff;
      zero_in = zero_ff;
      hb_in   = hb_ff;
      wc_in   = wc_ff;
      fw_in   = fw_ff;
      fd_in   = fd_ff;
      if (cmd.count) begin
         na_in   = cnt_a.cnt;
         nb_in   = cnt_b.cnt;
         nc_in   = cnt_c.cnt;
         err_in  = cnt_a.over | cnt_b.over | cnt_c.over;
         zero_in = (cnt_a.cnt == '0) | (cnt_b.cnt == '0) | (cnt_c.cnt == '0);
         hb_in   = HB_W'(h_ff) * HB_W'(ib_ff);
         wc_in   = HB_W'(w_ff) * HB_W'(cc_ff);
         fw_in   = HB_W'(f_ff) * HB_W'(w_ff);
         fd_in   = FD_W'(f_ff) * FD_W'(d_ff);
      end
   end

   always_comb begin
      wrow_step_in = wrow_step_ff;
      aj_step_in   = aj_step_ff;
      rem_a_in     = rem_a_ff;
      rem_b_in     = rem_b_ff;
      rem_c_in     = rem_c_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      wrow_in      = wrow_ff;
      wcur_in      = wcur_ff;
      akb_in       = akb_ff;
      acur_in      = acur_ff;
      id_in        = id_ff;
      if (cmd.scale) begin
         wrow_step_in = wrow_full[ADDR_W-1:0];
         aj_step_in   = aj_full[ADDR_W-1:0];
         rem_a_in     = diff_a[ARR_W-1:0];
         rem_b_in     = diff_b[ARR_W-1:0];
         rem_c_in     = diff_c[ACC_W-1:0];
         i_in         = '0;
         j_in         = '0;
         k_in         = '0;
         wrow_in      = wbase_ff;
         wcur_in      = wbase_ff;
         akb_in       = abase_ff;
         acur_in      = abase_ff;
      end else if (cmd.advance) begin
         id_in = id_ff + ID_W'(1);
         if (!j_last) begin
            j_in    = j_ff + IDX_W'(1);
            wcur_in = wcur_ff + ADDR_W'(fw_ff);
            acur_in = acur_ff + aj_step_ff;
         end else if (!k_last) begin
            j_in    = '0;
            k_in    = k_ff + IDX_W'(1);
            wcur_in = wrow_ff;
            akb_in  = akb_next;
            acur_in = akb_next;
         end else begin
            j_in    = '0;
            k_in    = '0;
            i_in    = i_ff + IDX_W'(1);
            wrow_in = wrow_next;
            wcur_in = wrow_next;
            akb_in  = abase_ff;
            acur_in = abase_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= ARRAY_WIDTH_RESET;
         cfg_h_ff <= ARRAY_HEIGHT_RESET;
         cfg_d_ff <= ACCUM_DEPTH_RESET;
         id_ff    <= TILE_ID_RESET;
      end else begin
         cfg_w_ff <= cfg_w_in;
         cfg_h_ff <= cfg_h_in;
         cfg_d_ff <= cfg_d_in;
         id_ff    <= id_in;
      end
   end

   always_ff @(posedge clock) begin
      ra_ff        <= ra_in;
      ib_ff        <= ib_in;
      cc_ff        <= cc_in;
      f_ff         <= f_in;
      wbase_ff     <= wbase_in;
      abase_ff     <= abase_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      d_ff         <= d_in;
      na_ff        <= na_in;
      nb_ff        <= nb_in;
      nc_ff        <= nc_in;
      err_ff       <= err_in;
      zero_ff      <= zero_in;
      hb_ff        <= hb_in;
      wc_ff        <= wc_in;
      fw_ff        <= fw_in;
      fd_ff        <= fd_in;
      wrow_step_ff <= wrow_step_in;
      aj_step_ff   <= aj_step_in;
      rem_a_ff     <= rem_a_in;
      rem_b_ff     <= rem_b_in;
      rem_c_ff     <= rem_c_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      wrow_ff      <= wrow_in;
      wcur_ff      <= wcur_in;
      akb_ff       <= akb_in;
      acur_ff      <= acur_in;
   end

   assign status.err  = err_ff;
   assign status.zero = zero_ff;
   assign status.last = i_last & j_last & k_last;

   always_comb begin
      if (cmd.show_err) begin
         rsp_payload       = '0;
         rsp_payload.last  = 1'b1;
         rsp_payload.error = 1'b1;
      end else begin
         rsp_payload.tile_id     = id_ff;
         rsp_payload.weight_addr = wcur_ff;
         rsp_payload.weight_cols = j_last ? rem_b_ff : w_ff;
         rsp_payload.weight_rows = i_last ? rem_a_ff : h_ff;
         rsp_payload.act_addr    = acur_ff;
         rsp_payload.act_cols    = k_last ? rem_c_ff : d_ff;
         rsp_payload.act_rows    = i_last ? rem_a_ff : h_ff;
         rsp_payload.full_cols   = ib_ff;
         rsp_payload.full_rows   = ra_ff;
         rsp_payload.last        = i_last & j_last & k_last;
         rsp_payload.error       = 1'b0;
      end
   end

endmodule

>>> src/mtag_checker.sv
module mtag_checker import mtag_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while a result item is pending");

   a_error_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.error |->
         rsp_payload.last && rsp_payload.tile_id == '0 && rsp_payload.weight_addr == '0)
      else $error("error item not last or not cleared");

   a_id_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.error && !rsp_payload.last |=>
         rsp_valid && rsp_payload.tile_id == $past(rsp_payload.tile_id) + ID_W'(1))
      else $error("tile id did not advance by one within a command");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result item changed");

endmodule

bind matmul_tile_address_generator_core mtag_checker u_mtag_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

>>> test/mtag_tile_checker.sv
module mtag_tile_checker import mtag_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_item,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_item,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                    pending_results,
   output int                    mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [ARR_W-1:0] array_width;
   logic [ARR_W-1:0] array_height;
   logic [ACC_W-1:0] accum_depth;
   logic [ID_W-1:0]  next_tile_id;
   rsp_payload_type  expected_tiles[$];

   function automatic int unsigned tiles_along(int unsigned total, int unsigned size);
      return (total == 0) ? 0 : (total - 1) / size + 1;
   endfunction

   function automatic void predict_tiles(req_payload_type cmd);
      int unsigned     w, h, d, na, nb, nc, rem_a, rem_b, rem_c, rows, i, j, k;
      logic [63:0]     factor, woff, aoff;
      rsp_payload_type t;
      w = (array_width == 0) ? 1 : array_width;
      h = (array_height == 0) ? 1 : array_height;
      d = (accum_depth == 0) ? 1 : accum_depth;
      na = tiles_along(cmd.rows_a, h);
      nb = tiles_along(cmd.inner_b, w);
      nc = tiles_along(cmd.cols_c, d);
      t = '0;
      if (na > MAX_TILES_PER_DIM || nb > MAX_TILES_PER_DIM || nc > MAX_TILES_PER_DIM) begin
         t.last = 1'b1;
         t.error = 1'b1;
         expected_tiles = {expected_tiles, t};
         return;
      end
      if (na == 0 || nb == 0 || nc == 0) return;
      rem_a = cmd.rows_a - (na - 1) * h;
      rem_b = cmd.inner_b - (nb - 1) * w;
      rem_c = cmd.cols_c - (nc - 1) * d;
      factor = cmd.layout_nchw ? 64'd1 : 64'(cmd.channels);
      for (i = 0; i < na; i++) begin
         for (k = 0; k < nc; k++) begin
            for (j = 0; j < nb; j++) begin
               woff = 64'(i) * 64'(h) * 64'(cmd.inner_b) + 64'(j) * 64'(w);
               aoff = 64'(j) * 64'(w) * 64'(cmd.cols_c) + 64'(k) * 64'(d);
               rows = (i == na - 1) ? rem_a : h;
               t.tile_id     = next_tile_id;
               t.weight_addr = ADDR_W'(64'(cmd.weight_base) + factor * woff);
               t.weight_cols = ARR_W'((j == nb - 1) ? rem_b : w);
               t.weight_rows = ARR_W'(rows);
               t.act_addr    = ADDR_W'(64'(cmd.act_base) + factor * aoff);
               t.act_cols    = ACC_W'((k == nc - 1) ? rem_c : d);
               t.act_rows    = ARR_W'(rows);
               t.full_cols   = cmd.inner_b;
               t.full_rows   = cmd.rows_a;
               t.last        = (i == na - 1) && (k == nc - 1) && (j == nb - 1);
               t.error       = 1'b0;
               expected_tiles = {expected_tiles, t};
               next_tile_id = next_tile_id + ID_W'(1);
            end
         end
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         array_width  = ARRAY_WIDTH_RESET;
         array_height = ARRAY_HEIGHT_RESET;
         accum_depth  = ACCUM_DEPTH_RESET;
         next_tile_id = TILE_ID_RESET;
         mismatches   = 0;
         expected_tiles.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ARRAY_WIDTH:  array_width  = csr_wr_data[ARR_W-1:0];
               CSR_ARRAY_HEIGHT: array_height = csr_wr_data[ARR_W-1:0];
               CSR_ACCUM_DEPTH:  accum_depth  = csr_wr_data[ACC_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) predict_tiles(req_item);
         if (rsp_valid && rsp_ready) begin
            if (expected_tiles.size() == 0) begin
               $error("tile item with none expected: tile_id 0x%0h", rsp_item.tile_id);
               mismatches++;
            end else begin
               want = expected_tiles.pop_front();
               check_field("tile_id", want.tile_id, rsp_item.tile_id);
               check_field("weight_addr", want.weight_addr, rsp_item.weight_addr);
               check_field("weight_cols", 32'(want.weight_cols), 32'(rsp_item.weight_cols));
               check_field("weight_rows", 32'(want.weight_rows), 32'(rsp_item.weight_rows));
               check_field("act_addr", want.act_addr, rsp_item.act_addr);
               check_field("act_cols", 32'(want.act_cols), 32'(rsp_item.act_cols));
               check_field("act_rows", 32'(want.act_rows), 32'(rsp_item.act_rows));
               check_field("full_cols", 32'(want.full_cols), 32'(rsp_item.full_cols));
               check_field("full_rows", 32'(want.full_rows), 32'(rsp_item.full_rows));
               check_field("last", 32'(want.last), 32'(rsp_item.last));
               check_field("error", 32'(want.error), 32'(rsp_item.error));
            end
         end
      end
      pending_results = expected_tiles.size();
   end

endmodule

>>> test/tb_matmul_tile_address_generator_core.sv
module tb_matmul_tile_address_generator_core;
   import mtag_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 22;
   localparam int PRESSURE_PHASE  = 1;
   localparam int PRESSURE_ITEMS  = 6;
   localparam int LONG_HOLD       = 400;
   localparam int SETTLE_CYCLES   = 10;
   localparam int WATCHDOG_LIMIT  = 3000;

   typedef enum int {DIM_FIT, DIM_OVER, DIM_NOISE, DIM_ZERO} dim_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    pending_results;
   int                    mismatches;
   int unsigned           idle_pct = 0;
   int unsigned           stall_pct = 0;
   int                    hold_requests = 0;
   int                    holds_done = 0;
   int                    quiet_cycles = 0;
   int unsigned           tile_w = 128;
   int unsigned           tile_h = 128;
   int unsigned           tile_d = 256;

   mtag_req_if req_if ();
   mtag_rsp_if rsp_if ();

   matmul_tile_address_generator_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   mtag_tile_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_item        (req_if.payload),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_item        (rsp_if.payload),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .pending_results (pending_results),
      .mismatches      (mismatches)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stall the tile output; a hold request blocks it for a long stretch
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_if.ready <= !reset && ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic req_payload_type make_command(
      logic [DIM_W-1:0] rows_a, logic [DIM_W-1:0] inner_b, logic [DIM_W-1:0] cols_c,
      logic nchw, logic [DIM_W-1:0] channels, logic [ADDR_W-1:0] weight_base,
      logic [ADDR_W-1:0] act_base);
      req_payload_type c;
      c.rows_a      = rows_a;
      c.inner_b     = inner_b;
      c.cols_c      = cols_c;
      c.layout_nchw = nchw;
      c.channels    = channels;
      c.weight_base = weight_base;
      c.act_base    = act_base;
      return c;
   endfunction

   function automatic logic [DIM_W-1:0] random_dim(int unsigned size, dim_kind_type kind);
      int unsigned s, span;
      s = (size == 0) ? 1 : size;
      span = (4 * s > 65535) ? 65535 : 4 * s;
      case (kind)
         DIM_ZERO:  return '0;
         DIM_NOISE: return DIM_W'($urandom);
         DIM_OVER:  begin
            if (span < 65535) return DIM_W'($urandom_range(65535, span + 1));
            return DIM_W'($urandom_range(span, 1));
         end
         default: begin
            if ($urandom_range(3) == 0) return DIM_W'(s * $urandom_range(4, 1));
            return DIM_W'($urandom_range(span, 1));
         end
      endcase
   endfunction

   task automatic send_command(input req_payload_type cmd);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= cmd;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic drain_tiles();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h,
                              input logic [CSR_DATA_W-1:0] d);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_ARRAY_WIDTH;
      csr_wr_data <= w;
      @(posedge clock);
      csr_index   <= CSR_ARRAY_HEIGHT;
      csr_wr_data <= h;
      @(posedge clock);
      csr_index   <= CSR_ACCUM_DEPTH;
      csr_wr_data <= d;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tile_w = w[ARR_W-1:0];
      tile_h = h[ARR_W-1:0];
      tile_d = d;
   endtask

   initial begin
      req_payload_type directed[$];
      dim_kind_type    kinds[3];
      int unsigned     pick, odd_dim, mode_idle, phase, n;
      req_payload_type cmd;

      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_ARRAY_WIDTH;
      csr_wr_data    = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = {directed, make_command(1, 1, 1, 1'b1, 1, 32'h0, 32'h0)};
      directed = {directed, make_command(512, 512, 1024, 1'b1, 5, 32'hFFFF_FFFF,
                                         32'hFFFF_FFFF)};
      directed = {directed, make_command(512, 512, 1024, 1'b0, 16'hFFFF, 32'h8000_0000,
                                         32'h7FFF_FFFF)};
      directed = {directed, make_command(513, 1, 1, 1'b1, 1, 32'h1234, 32'h5678)};
      directed = {directed, make_command(1, 513, 1, 1'b0, 7, 32'h1234, 32'h5678)};
      directed = {directed, make_command(1, 1, 1025, 1'b1, 1, 32'h1234, 32'h5678)};
      directed = {directed, make_command(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF,
                                         32'hFFFF_FFFF, 32'hFFFF_FFFF)};
      directed = {directed, make_command(0, 5, 5, 1'b1, 1, 32'h100, 32'h200)};
      directed = {directed, make_command(5, 0, 5, 1'b0, 3, 32'h100, 32'h200)};
      directed = {directed, make_command(5, 5, 0, 1'b1, 1, 32'h100, 32'h200)};
      directed = {directed, make_command(0, 0, 0, 1'b0, 0, 32'h0, 32'h0)};
      directed = {directed, make_command(0, 1000, 1, 1'b1, 1, 32'h0, 32'h0)};
      directed = {directed, make_command(300, 200, 600, 1'b0, 0, 32'hDEAD_BEEF,
                                         32'hCAFE_F00D)};
      directed = {directed, make_command(128, 128, 256, 1'b0, 2, 32'h1000, 32'h2000)};
      directed = {directed, make_command(129, 129, 257, 1'b0, 3, 32'hFFFF_FF00,
                                         32'hFFFF_F000)};
      directed = {directed, make_command(384, 100, 700, 1'b1, 16'h8000, 32'h4000_0000,
                                         32'h1)};
      foreach (directed[i]) send_command(directed[i]);
      drain_tiles();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       load_config(0, 0, 0);
            1:       load_config(511, 511, 8191);
            2:       load_config(1, 1, 1);
            3:       load_config(256, 256, 4096);
            default: load_config($urandom_range(256, 1), $urandom_range(256, 1),
                                 $urandom_range(4096, 1));
         endcase
         mode_idle = (phase % 4 == 1 || phase % 4 == 3) ? ((phase % 4 == 1) ? 85 : 21) : 0;
         stall_pct = (phase % 4 == 2) ? 85 : ((phase % 4 == 3) ? 21 : 0);
         if (phase == PRESSURE_PHASE) hold_requests++;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            idle_pct = (phase == PRESSURE_PHASE && n < PRESSURE_ITEMS) ? 0 : mode_idle;
            kinds[0] = DIM_FIT;
            kinds[1] = DIM_FIT;
            kinds[2] = DIM_FIT;
            pick = $urandom_range(99);
            odd_dim = $urandom_range(2);
            if (pick >= 75 && pick < 87) begin
               kinds[0] = DIM_NOISE;
               kinds[1] = DIM_NOISE;
               kinds[2] = DIM_NOISE;
            end else if (pick >= 87 && pick < 94) begin
               kinds[odd_dim] = DIM_OVER;
            end else if (pick >= 94) begin
               kinds[odd_dim] = DIM_ZERO;
            end
            cmd.rows_a      = random_dim(tile_h, kinds[0]);
            cmd.inner_b     = random_dim(tile_w, kinds[1]);
            cmd.cols_c      = random_dim(tile_d, kinds[2]);
            cmd.layout_nchw = $urandom_range(1);
            cmd.channels    = ($urandom_range(9) == 0) ? '0 : DIM_W'($urandom);
            cmd.weight_base = $urandom;
            cmd.act_base    = $urandom;
            send_command(cmd);
         end
         idle_pct = 0;
         drain_tiles();
         stall_pct = 0;
      end

      if (mismatches == 0 && pending_results == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> matmul_tile_address_generator_core.f
src/mtag_pkg.sv
src/mtag_if.sv
src/mtag_ctrl.sv
src/mtag_datapath.sv
src/matmul_tile_address_generator_core.sv
src/mtag_checker.sv
test/mtag_tile_checker.sv
test/tb_matmul_tile_address_generator_core.sv
